// ===== rtl/core/pmtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor torque controller package
// Shared types, register indexes, saturation helpers and the control program.
// ----------------------------------------------------------------------------
package pmtc_pkg;

    localparam int QW        = 32;
    localparam int GEAR_W    = 31;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd4;

    localparam logic [MODE_W-1:0] MODE_POSITION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TORQUE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    localparam logic [GEAR_W-1:0] GEAR_RESET = 31'd65536;

    typedef struct packed {
        logic signed [QW-1:0] pos_measured;
        logic signed [QW-1:0] vel_measured;
        logic signed [QW-1:0] pos_target;
        logic signed [QW-1:0] vel_target;
        logic signed [QW-1:0] torque_feedforward;
    } t_in_item;

    typedef struct packed {
        logic signed [QW-1:0] drive_torque;
        logic signed [QW-1:0] previous_torque;
    } t_out_item;

    typedef enum logic [1:0] {
        A_PT = 2'd0,
        A_VT = 2'd1,
        A_EP = 2'd2,
        A_EV = 2'd3
    } t_asel;

    typedef enum logic [1:0] {
        B_GR = 2'd0,
        B_KP = 2'd1,
        B_KD = 2'd2,
        B_KI = 2'd3
    } t_bsel;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_DIV_START = 4'd1,
        OP_WR_PC     = 4'd2,
        OP_WR_VC     = 4'd3,
        OP_WR_EP     = 4'd4,
        OP_WR_EV     = 4'd5,
        OP_ACC_I     = 4'd6,
        OP_SUM_QM    = 4'd7,
        OP_SUM_INT   = 4'd8,
        OP_SUM_TC    = 4'd9,
        OP_FINISH    = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        J_NONE     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_VEL      = 3'd2,
        J_NPOS     = 3'd3,
        J_DIV_BUSY = 3'd4
    } t_jcond;

    typedef struct packed {
        logic              mul_en;
        t_asel             a_sel;
        t_bsel             b_sel;
        t_op               op;
        t_jcond            jc;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_uword;

    localparam logic [STEP_W-1:0] L_VEL  = 4'd10;
    localparam logic [STEP_W-1:0] L_WAIT = 4'd12;

    function automatic t_uword f_uw(input logic mul_en, input t_asel a, input t_bsel b,
                                    input t_op op, input t_jcond jc,
                                    input logic [STEP_W-1:0] tgt, input logic last);
        t_uword w;
        w.mul_en = mul_en;
        w.a_sel  = a;
        w.b_sel  = b;
        w.op     = op;
        w.jc     = jc;
        w.target = tgt;
        w.last   = last;
        return w;
    endfunction

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            4'd0:    w = f_uw(1'b1, A_PT, B_GR, OP_DIV_START, J_NONE, '0, 1'b0);
            4'd1:    w = f_uw(1'b1, A_VT, B_GR, OP_WR_PC, J_NONE, '0, 1'b0);
            4'd2:    w = f_uw(1'b0, A_PT, B_GR, OP_WR_VC, J_NONE, '0, 1'b0);
            4'd3:    w = f_uw(1'b0, A_PT, B_GR, OP_WR_EV, J_VEL, L_VEL, 1'b0);
            4'd4:    w = f_uw(1'b0, A_PT, B_GR, OP_WR_EP, J_NPOS, L_WAIT, 1'b0);
            4'd5:    w = f_uw(1'b1, A_EP, B_KI, OP_NOP, J_NONE, '0, 1'b0);
            4'd6:    w = f_uw(1'b1, A_EP, B_KP, OP_ACC_I, J_NONE, '0, 1'b0);
            4'd7:    w = f_uw(1'b1, A_EV, B_KD, OP_SUM_QM, J_NONE, '0, 1'b0);
            4'd8:    w = f_uw(1'b0, A_PT, B_GR, OP_SUM_QM, J_NONE, '0, 1'b0);
            4'd9:    w = f_uw(1'b0, A_PT, B_GR, OP_SUM_INT, J_ALWAYS, L_WAIT, 1'b0);
            4'd10:   w = f_uw(1'b1, A_EV, B_KP, OP_NOP, J_NONE, '0, 1'b0);
            4'd11:   w = f_uw(1'b0, A_PT, B_GR, OP_SUM_QM, J_NONE, '0, 1'b0);
            4'd12:   w = f_uw(1'b0, A_PT, B_GR, OP_NOP, J_DIV_BUSY, L_WAIT, 1'b0);
            4'd13:   w = f_uw(1'b0, A_PT, B_GR, OP_SUM_TC, J_NONE, '0, 1'b0);
            4'd14:   w = f_uw(1'b0, A_PT, B_GR, OP_FINISH, J_NONE, '0, 1'b1);
            default: w = f_uw(1'b0, A_PT, B_GR, OP_FINISH, J_NONE, '0, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic signed [QW-1:0] f_sat33(input logic signed [QW:0] v);
        logic signed [QW-1:0] r;
        if (v[QW] == v[QW-1]) begin
            r = v[QW-1:0];
        end else begin
            r = v[QW] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] f_sat35(input logic signed [QW+2:0] v);
        logic signed [QW-1:0] r;
        if (v[QW+2:QW-1] == '0 || v[QW+2:QW-1] == '1) begin
            r = v[QW-1:0];
        end else begin
            r = v[QW+2] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    // Floor of the Q16.16 product, then saturation to 32 bits.
    function automatic logic signed [QW-1:0] f_qmul_sat(input logic signed [2*QW+1:0] p);
        logic signed [2*QW+1:0] sh;
        logic signed [QW-1:0]   r;
        sh = p >>> 16;
        if (sh[2*QW+1:QW-1] == '0 || sh[2*QW+1:QW-1] == '1) begin
            r = sh[QW-1:0];
        end else begin
            r = sh[2*QW+1] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pmtc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Torque command divider
// Restoring division of the feed-forward torque, scaled by 2^16, by the gear
// ratio, one quotient bit per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module pmtc_div
    import pmtc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [QW-1:0]    i_dividend,
    input  wire logic [GEAR_W-1:0]       i_divisor,
    output logic                         o_busy,
    output logic signed [QW-1:0]         o_quot
);

    localparam int NUM_W = QW + 16;
    localparam int CNT_W = $clog2(NUM_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [GEAR_W-1:0]    r_rem;
    logic [NUM_W-1:0]     r_num;
    logic [GEAR_W-1:0]    r_div;
    logic                 r_neg;
    logic                 r_zero;

    logic [QW-1:0]        w_mag;
    logic [GEAR_W:0]      w_rem_s;
    logic                 w_ge;
    logic [GEAR_W:0]      w_rem_sub;

    assign w_mag     = i_dividend[QW-1] ? (QW)'(-i_dividend) : i_dividend;
    assign w_rem_s   = {r_rem, r_num[NUM_W-1]};
    assign w_ge      = w_rem_s >= {1'b0, r_div};
    assign w_rem_sub = w_rem_s - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == (CNT_W)'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_num  <= {w_mag, 16'h0000};
            r_div  <= i_divisor;
            r_neg  <= i_dividend[QW-1];
            r_zero <= (i_dividend == '0);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[GEAR_W-1:0] : w_rem_s[GEAR_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (!r_neg) begin
            o_quot = (r_num[NUM_W-1:QW-1] != '0) ? Q_MAX : $signed({1'b0, r_num[QW-2:0]});
        end else if (r_num[NUM_W-1:QW] != '0 || (r_num[QW-1] && r_num[QW-2:0] != '0)) begin
            o_quot = Q_MIN;
        end else begin
            o_quot = $signed(-r_num[QW-1:0]);
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// ===== rtl/core/pid_motor_torque_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PID motor torque controller, top level
// A microprogrammed sequencer drives one shared multiplier and a saturating
// adder to form the position, velocity or torque law, while a bit-serial
// divider forms the torque command in parallel.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  input    | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  output   | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  config   | in        | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
// The multiply program runs beside the divider and waits for its quotient
// before adding it in. Reset is synchronous and active low; it clears the
// state, the configuration, the integrator, the last torque and the output
// valid flag. A result waits in the output register; the next item is taken
// meanwhile, and the last step holds while that register is full and unread.
// ----------------------------------------------------------------------------
module pid_motor_torque_controller_top
    import pmtc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [QW-1:0]         i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_W-1:0]    r_step, n_step;

    logic [GEAR_W-1:0]    r_gear;
    logic [MODE_W-1:0]    r_mode;
    logic signed [QW-1:0] r_kp, r_kd, r_ki;

    t_in_item             r_in;
    logic signed [QW-1:0] r_pc, r_vc, r_ep, r_ev;
    logic signed [2*QW+1:0] r_prod;
    logic signed [QW+2:0] r_sum;
    logic signed [QW-1:0] r_integral, r_last;
    logic                 r_out_valid;
    t_out_item            r_out;

    t_uword               w_uw;
    logic                 w_in_xfer, w_stall, w_jump, w_div_start, w_div_busy;
    logic signed [QW-1:0] w_qm, w_tc, w_drive;
    logic signed [QW:0]   w_ma, w_mb;

    assign w_uw        = f_ucode(r_step);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_stall     = (r_state == S_RUN) && (w_uw.op == OP_FINISH)
                         && r_out_valid && !i_out_ready;
    assign w_div_start = (r_state == S_RUN) && (w_uw.op == OP_DIV_START);
    assign w_qm        = f_qmul_sat(r_prod);
    assign w_drive     = (r_mode == MODE_UNUSED) ? r_last : f_sat35(r_sum);

    pmtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_in.torque_feedforward),
        .i_divisor  (r_gear),
        .o_busy     (w_div_busy),
        .o_quot     (w_tc)
    );

    always_comb begin
        case (w_uw.jc)
            J_NONE:     w_jump = 1'b0;
            J_ALWAYS:   w_jump = 1'b1;
            J_VEL:      w_jump = (r_mode == MODE_VELOCITY);
            J_NPOS:     w_jump = (r_mode != MODE_POSITION);
            J_DIV_BUSY: w_jump = w_div_busy;
            default:    w_jump = 1'b0;
        endcase
    end

    always_comb begin
        case (w_uw.a_sel)
            A_PT:    w_ma = {r_in.pos_target[QW-1], r_in.pos_target};
            A_VT:    w_ma = {r_in.vel_target[QW-1], r_in.vel_target};
            A_EP:    w_ma = {r_ep[QW-1], r_ep};
            A_EV:    w_ma = {r_ev[QW-1], r_ev};
            default: w_ma = '0;
        endcase
        case (w_uw.b_sel)
            B_GR:    w_mb = $signed({2'b00, r_gear});
            B_KP:    w_mb = {r_kp[QW-1], r_kp};
            B_KD:    w_mb = {r_kd[QW-1], r_kd};
            B_KI:    w_mb = {r_ki[QW-1], r_ki};
            default: w_mb = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (!w_stall) begin
                    if (w_uw.last) begin
                        n_state = S_IDLE;
                    end else if (w_jump) begin
                        n_step = w_uw.target;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear <= GEAR_RESET;
            r_mode <= MODE_TORQUE;
            r_kp   <= '0;
            r_kd   <= '0;
            r_ki   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GEAR_RATIO:   r_gear <= i_cfg_wdata[GEAR_W-1:0];
                CFG_CONTROL_MODE: r_mode <= i_cfg_wdata[MODE_W-1:0];
                CFG_GAIN_P:       r_kp   <= $signed(i_cfg_wdata);
                CFG_GAIN_D:       r_kd   <= $signed(i_cfg_wdata);
                CFG_GAIN_I:       r_ki   <= $signed(i_cfg_wdata);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
        if (r_state == S_RUN && w_uw.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        if (r_state == S_RUN) begin
            case (w_uw.op)
                OP_DIV_START: r_sum <= '0;
                OP_WR_PC:     r_pc  <= w_qm;
                OP_WR_VC:     r_vc  <= w_qm;
                OP_WR_EP:     r_ep  <= f_sat33({r_pc[QW-1], r_pc}
                                      - {r_in.pos_measured[QW-1], r_in.pos_measured});
                OP_WR_EV:     r_ev  <= f_sat33({r_vc[QW-1], r_vc}
                                      - {r_in.vel_measured[QW-1], r_in.vel_measured});
                OP_SUM_QM:    r_sum <= r_sum + {{3{w_qm[QW-1]}}, w_qm};
                OP_SUM_INT:   r_sum <= r_sum + {{3{r_integral[QW-1]}}, r_integral};
                OP_SUM_TC:    r_sum <= r_sum + {{3{w_tc[QW-1]}}, w_tc};
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_RUN && w_uw.op == OP_ACC_I) begin
                r_integral <= f_sat33({r_integral[QW-1], r_integral} + {w_qm[QW-1], w_qm});
            end
            if (r_state == S_RUN && w_uw.op == OP_FINISH && !w_stall) begin
                r_last      <= w_drive;
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && w_uw.op == OP_FINISH && !w_stall) begin
            r_out.drive_torque    <= w_drive;
            r_out.previous_torque <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID motor torque controller testbench
// Control ticks are offered from a queue under random idling and a long
// output hold-off. Each accepted transfer is run through a cycle-free model
// of the position, velocity and torque laws with their own gain, gear and
// integrator state, and every result transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import pmtc_pkg::*;

    localparam int     CYCLE_LIMIT     = 400_000;
    localparam int     LONG_HOLD       = 400;
    localparam int     RAND_PHASES     = 12;
    localparam int     TICKS_PER_PHASE = 50;
    localparam int     TAIL_CYCLES     = 80;
    localparam longint Q_HI            = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_LO            = 64'shFFFF_FFFF_8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [QW-1:0]        i_cfg_wdata;

    logic [GEAR_W-1:0]    cfg_gear;
    logic [MODE_W-1:0]    cfg_mode;
    logic signed [QW-1:0] cfg_kp;
    logic signed [QW-1:0] cfg_kd;
    logic signed [QW-1:0] cfg_ki;
    logic signed [QW-1:0] integ_acc;
    logic signed [QW-1:0] prior_drive;

    t_in_item  pending_ticks[$];
    t_out_item expected_torques[$];
    int        outstanding_ticks = 0;
    int        mismatches        = 0;
    int        cycle_count       = 0;
    int        send_gap          = 0;
    int        stall_left        = 0;
    bit        tick_taken        = 1'b0;
    bit        idling_on         = 1'b1;
    bit        long_hold_req     = 1'b0;

    pid_motor_torque_controller_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint clamp_q(input longint v);
        longint r;
        r = v;
        if (v > Q_HI) begin
            r = Q_HI;
        end else if (v < Q_LO) begin
            r = Q_LO;
        end
        return r;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp_q((a * b) >>> 16);
    endfunction

    function automatic t_out_item predict_torque(input t_in_item tick);
        longint    pm, vm, pt, vt, tf, gr, pc, vc, tc, ep, ev, acc, drv;
        t_out_item r;
        pm = longint'($signed(tick.pos_measured));
        vm = longint'($signed(tick.vel_measured));
        pt = longint'($signed(tick.pos_target));
        vt = longint'($signed(tick.vel_target));
        tf = longint'($signed(tick.torque_feedforward));
        gr = longint'({1'b0, cfg_gear});
        pc = qmul(pt, gr);
        vc = qmul(vt, gr);
        if (gr == 0) begin
            tc = (tf > 0) ? Q_HI : ((tf < 0) ? Q_LO : 0);
        end else begin
            tc = clamp_q((tf * 65536) / gr);
        end
        case (cfg_mode)
            MODE_POSITION: begin
                ep  = clamp_q(pc - pm);
                ev  = clamp_q(vc - vm);
                acc = clamp_q(longint'(integ_acc) + qmul(ep, longint'(cfg_ki)));
                integ_acc = acc[QW-1:0];
                drv = clamp_q(tc + qmul(ep, longint'(cfg_kp)) + qmul(ev, longint'(cfg_kd))
                              + acc);
            end
            MODE_VELOCITY: begin
                ev  = clamp_q(vc - vm);
                drv = clamp_q(tc + qmul(ev, longint'(cfg_kp)));
            end
            MODE_TORQUE: begin
                drv = tc;
            end
            default: begin
                drv = longint'(prior_drive);
            end
        endcase
        r.drive_torque    = drv[QW-1:0];
        r.previous_torque = prior_drive;
        prior_drive       = drv[QW-1:0];
        return r;
    endfunction

    function automatic logic signed [QW-1:0] rand_q();
        logic signed [QW-1:0] r;
        case ($urandom_range(0, 9))
            0:       r = Q_MAX;
            1:       r = Q_MIN;
            2:       r = '0;
            3, 4, 5: r = $urandom;
            default: r = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
        return r;
    endfunction

    function automatic logic [QW-1:0] rand_gear_word();
        logic [QW-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0:       w[GEAR_W-1:0] = '0;
            1:       w[GEAR_W-1:0] = 31'd1;
            2:       w[GEAR_W-1:0] = '1;
            3:       w[GEAR_W-1:0] = GEAR_RESET;
            4:       w[GEAR_W-1:0] = (GEAR_W)'($urandom);
            default: w[GEAR_W-1:0] = (GEAR_W)'($urandom_range(32'h0000_1000, 32'h0010_0000));
        endcase
        return w;
    endfunction

    function automatic logic [QW-1:0] rand_mode_word();
        logic [QW-1:0] w;
        int            pick;
        w    = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            w[MODE_W-1:0] = MODE_POSITION;
        end else if (pick < 7) begin
            w[MODE_W-1:0] = MODE_VELOCITY;
        end else if (pick < 9) begin
            w[MODE_W-1:0] = MODE_TORQUE;
        end else begin
            w[MODE_W-1:0] = MODE_UNUSED;
        end
        return w;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [QW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_GEAR_RATIO:   cfg_gear = data[GEAR_W-1:0];
            CFG_CONTROL_MODE: cfg_mode = data[MODE_W-1:0];
            CFG_GAIN_P:       cfg_kp   = data;
            CFG_GAIN_D:       cfg_kd   = data;
            CFG_GAIN_I:       cfg_ki   = data;
            default: ;
        endcase
    endtask

    task automatic push_tick(input logic signed [QW-1:0] pm, input logic signed [QW-1:0] vm,
                             input logic signed [QW-1:0] pt, input logic signed [QW-1:0] vt,
                             input logic signed [QW-1:0] tf);
        t_in_item t;
        t.pos_measured       = pm;
        t.vel_measured       = vm;
        t.pos_target         = pt;
        t.vel_target         = vt;
        t.torque_feedforward = tf;
        pending_ticks.push_back(t);
        outstanding_ticks++;
    endtask

    task automatic wait_drained();
        while (outstanding_ticks != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_ticks
        logic     v_next;
        t_in_item d_next;
        v_next = i_in_valid;
        d_next = i_in_data;
        if (tick_taken) begin
            v_next     = 1'b0;
            tick_taken = 1'b0;
        end
        if (!v_next && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 8) - 1;
            end else if (pending_ticks.size() > 0) begin
                d_next = pending_ticks.pop_front();
                v_next = 1'b1;
            end
        end
        i_in_valid <= v_next;
        i_in_data  <= d_next;
    end

    always @(negedge i_clk) begin : drive_ready
        logic r_next;
        r_next = 1'b1;
        if (!i_rst_n) begin
            r_next = 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD - 1;
            r_next        = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            r_next = 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            r_next     = 1'b0;
        end
        i_out_ready <= r_next;
    end

    always @(posedge i_clk) begin : check_torque
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_torques.size() == 0) begin
                $error("drive_torque: expected none, actual %0d",
                       $signed(o_out_data.drive_torque));
                mismatches++;
            end else begin
                want = expected_torques.pop_front();
                outstanding_ticks--;
                if (o_out_data.drive_torque !== want.drive_torque) begin
                    $error("drive_torque: expected %0d, actual %0d",
                           $signed(want.drive_torque), $signed(o_out_data.drive_torque));
                    mismatches++;
                end
                if (o_out_data.previous_torque !== want.previous_torque) begin
                    $error("previous_torque: expected %0d, actual %0d",
                           $signed(want.previous_torque), $signed(o_out_data.previous_torque));
                    mismatches++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_torques.push_back(predict_torque(i_in_data));
            tick_taken = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        cfg_gear    = GEAR_RESET;
        cfg_mode    = MODE_TORQUE;
        cfg_kp      = '0;
        cfg_kd      = '0;
        cfg_ki      = '0;
        integ_acc   = '0;
        prior_drive = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Torque passthrough at the reset configuration.
        push_tick('0, '0, '0, '0, Q_MAX);
        push_tick('0, '0, '0, '0, Q_MIN);
        push_tick(Q_MAX, Q_MIN, Q_MAX, Q_MIN, -32'sd1);
        wait_drained();

        // Zero gear ratio in position mode; a nonzero feed-forward sends the torque command to a limit.
        cfg_write(CFG_GEAR_RATIO, {1'b1, 31'd0});
        cfg_write(CFG_CONTROL_MODE, {30'h3FFF_FFFF, MODE_POSITION});
        cfg_write(CFG_GAIN_P, 32'h0001_0000);
        cfg_write(CFG_GAIN_D, 32'h0000_8000);
        cfg_write(CFG_GAIN_I, 32'h0000_4000);
        push_tick(32'sh0001_0000, -32'sh0002_0000, Q_MAX, Q_MIN, 32'sd5);
        push_tick(-32'sh0003_0000, 32'sh0000_8000, Q_MIN, Q_MAX, -32'sd5);
        push_tick(Q_MAX, Q_MIN, '0, '0, '0);
        wait_drained();

        // Largest gear and extreme gains drive the gear products, the position error
        // and the integrator into saturation in both directions.
        cfg_write(CFG_GEAR_RATIO, {1'b0, 31'h7FFF_FFFF});
        cfg_write(CFG_GAIN_P, Q_MAX);
        cfg_write(CFG_GAIN_D, Q_MIN);
        cfg_write(CFG_GAIN_I, Q_MAX);
        push_tick(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_tick(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_tick(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_tick(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        wait_drained();

        cfg_write(CFG_GEAR_RATIO, 32'h0000_0001);
        cfg_write(CFG_CONTROL_MODE, {30'h2AAA_AAAA, MODE_VELOCITY});
        cfg_write(CFG_GAIN_P, 32'hFFFF_0000);
        repeat (3) push_tick(rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
        wait_drained();

        // The unused mode holds the prior torque; unmapped indexes are ignored.
        cfg_write(CFG_CONTROL_MODE, {30'h0, MODE_UNUSED});
        cfg_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_HI, 32'h0000_0000);
        repeat (3) push_tick(rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idling_on = (ph < RAND_PHASES - 2);
            cfg_write(CFG_GEAR_RATIO, rand_gear_word());
            cfg_write(CFG_CONTROL_MODE, rand_mode_word());
            cfg_write(CFG_GAIN_P, rand_q());
            cfg_write(CFG_GAIN_D, rand_q());
            cfg_write(CFG_GAIN_I, rand_q());
            if (ph == 2) begin
                long_hold_req = 1'b1;
            end
            repeat (TICKS_PER_PHASE) begin
                push_tick(rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_torques.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
